[sv/sia_pkg.sv]
// sia_pkg: shared types and constants of the session id allocator.
// No dependencies; used by the interfaces, controller, datapath and top level.
package sia_pkg;

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned ID_W = 16;
  localparam int unsigned OCC_W = 6;
  localparam int unsigned STATUS_W = 2;
  localparam logic [ID_W-1:0] ID_BASE_RESET = 16'd1000;

  localparam logic REQ_LOGIN = 1'b0;
  localparam logic REQ_LOGOUT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 2'd0,
    ST_FULL      = 2'd1,
    ST_REMOVED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic update;
  } sia_cmd_t;

  typedef struct packed {
    logic slot_free;
  } sia_stat_t;

endpackage

[sv/sia_ifs.sv]
// sia_ifs: valid/ready channel interfaces for requests, responses and config.
// Depends on sia_pkg for field widths.
interface sia_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [sia_pkg::HANDLE_W-1:0]  handle;
  modport source (output valid, req_type, handle, input ready);
  modport sink (input valid, req_type, handle, output ready);
endinterface

interface sia_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sia_pkg::STATUS_W-1:0]  status;
  logic [sia_pkg::ID_W-1:0]      session_id;
  logic [sia_pkg::OCC_W-1:0]     occupancy;
  modport source (output valid, status, session_id, occupancy, input ready);
  modport sink (input valid, status, session_id, occupancy, output ready);
endinterface

interface sia_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [sia_pkg::ID_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[sv/session_id_allocator.sv]
// session_id_allocator: top level joining the controller and the datapath.
// Depends on sia_pkg, sia_ifs, sia_ctrl and sia_dp.
//
// Keeps up to MAX_SESSIONS open sessions in arrival order. A login (req_type 0)
// appends the handle with the lowest free id at or above id_base; a logout
// (req_type 1) removes the oldest entry with that handle and reports its id.
// Every request yields one response with status, id and occupancy. A request
// passes through S_SEARCH, which compares the handle against all entries and
// picks the lowest free offset, and S_UPDATE, which updates the table and
// loads the response register. A new request is taken while a response waits,
// but the update stalls until the response register is free. Write id_base
// only when idle; open ids follow a new base.
module session_id_allocator #(
  parameter int unsigned MAX_SESSIONS = 32
) (
  input logic       clk,
  input logic       rst,
  sia_req_if.sink   req,
  sia_rsp_if.source rsp,
  sia_cfg_if.sink   cfg
);

  sia_pkg::sia_cmd_t  cmd;
  sia_pkg::sia_stat_t stat;
  logic               in_ready;

  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;

  sia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sia_dp #(
    .MAX_SESSIONS (MAX_SESSIONS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (req.req_type),
    .in_handle      (req.handle),
    .cfg_we         (cfg.valid),
    .cfg_data       (cfg.data),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_status     (rsp.status),
    .out_session_id (rsp.session_id),
    .out_occupancy  (rsp.occupancy)
  );

endmodule

[sv/sia_ctrl.sv]
// sia_ctrl: request sequencing state machine (accept, search, update).
// Depends on sia_pkg for the state, command and status types.
module sia_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  sia_pkg::sia_stat_t stat,
  output logic               in_ready,
  output sia_pkg::sia_cmd_t  cmd
);

  sia_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sia_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sia_pkg::S_IDLE: begin
        if (in_valid) state_next = sia_pkg::S_SEARCH;
      end
      sia_pkg::S_SEARCH: begin
        state_next = sia_pkg::S_UPDATE;
      end
      sia_pkg::S_UPDATE: begin
        if (stat.slot_free) begin
          state_next = in_valid ? sia_pkg::S_SEARCH : sia_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sia_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.search = 1'b0;
    cmd.update = 1'b0;
    case (state)
      sia_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      sia_pkg::S_SEARCH: begin
        cmd.search = 1'b1;
      end
      sia_pkg::S_UPDATE: begin
        in_ready   = stat.slot_free;
        cmd.update = stat.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.load = in_ready & in_valid;
  end

endmodule

[sv/sia_dp.sv]
// sia_dp: session table, offset bitmap, match/free search and response register.
// Depends on sia_pkg for widths, codes and the command/status types.
module sia_dp #(
  parameter int unsigned MAX_SESSIONS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sia_pkg::sia_cmd_t             cmd,
  output sia_pkg::sia_stat_t            stat,
  input  logic                          in_req_type,
  input  logic [sia_pkg::HANDLE_W-1:0]  in_handle,
  input  logic                          cfg_we,
  input  logic [sia_pkg::ID_W-1:0]      cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [sia_pkg::STATUS_W-1:0]  out_status,
  output logic [sia_pkg::ID_W-1:0]      out_session_id,
  output logic [sia_pkg::OCC_W-1:0]     out_occupancy
);

  localparam int unsigned OFF_W = $clog2(MAX_SESSIONS);
  localparam int unsigned CNT_W = $clog2(MAX_SESSIONS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SESSIONS);

  logic [sia_pkg::HANDLE_W-1:0] ent_handle [MAX_SESSIONS];
  logic [OFF_W-1:0]             ent_offset [MAX_SESSIONS];
  logic [CNT_W-1:0]             count, count_next;
  logic [MAX_SESSIONS-1:0]      used, used_next;
  logic [MAX_SESSIONS-1:0]      hit, free;
  logic [sia_pkg::ID_W-1:0]     id_base;
  logic                         req_type;
  logic [sia_pkg::HANDLE_W-1:0] req_handle;

  logic [MAX_SESSIONS-1:0] match, avail, shift_ge;
  logic [OFF_W-1:0]        free_off, freed_off;
  logic                    login_ok, logout_hit;
  logic [sia_pkg::STATUS_W-1:0] rsp_status;
  logic [sia_pkg::ID_W-1:0]     rsp_id;

  assign stat.slot_free = ~out_valid | out_ready;

  always_comb begin
    for (int g = 0; g < MAX_SESSIONS; g++) begin
      match[g] = (CNT_W'(g) < count) && (ent_handle[g] == req_handle);
    end
    avail = ~used;
  end

  always_comb begin
    free_off  = '0;
    freed_off = '0;
    for (int g = 0; g < MAX_SESSIONS; g++) begin
      if (free[g]) free_off = free_off | OFF_W'(g);
      if (hit[g]) freed_off = freed_off | ent_offset[g];
    end
  end

  assign shift_ge   = ~(hit - MAX_SESSIONS'(1));
  assign login_ok   = (req_type == sia_pkg::REQ_LOGIN) && (count != CNT_MAX);
  assign logout_hit = (req_type == sia_pkg::REQ_LOGOUT) && (hit != '0);

  always_comb begin
    count_next = count;
    used_next  = used;
    rsp_id     = '0;
    if (req_type == sia_pkg::REQ_LOGIN) begin
      if (login_ok) begin
        rsp_status = sia_pkg::ST_GRANTED;
        rsp_id     = id_base + sia_pkg::ID_W'(free_off);
        count_next = count + CNT_W'(1);
        used_next  = used | free;
      end else begin
        rsp_status = sia_pkg::ST_FULL;
      end
    end else begin
      if (logout_hit) begin
        rsp_status = sia_pkg::ST_REMOVED;
        rsp_id     = id_base + sia_pkg::ID_W'(freed_off);
        count_next = count - CNT_W'(1);
        for (int g = 0; g < MAX_SESSIONS; g++) begin
          if (freed_off == OFF_W'(g)) used_next[g] = 1'b0;
        end
      end else begin
        rsp_status = sia_pkg::ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      used      <= '0;
      id_base   <= sia_pkg::ID_BASE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) id_base <= cfg_data;
      if (cmd.update) begin
        count     <= count_next;
        used      <= used_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type   <= in_req_type;
      req_handle <= in_handle;
    end
    if (cmd.search) begin
      hit  <= match & (~match + MAX_SESSIONS'(1));
      free <= avail & (~avail + MAX_SESSIONS'(1));
    end
    if (cmd.update) begin
      out_status     <= rsp_status;
      out_session_id <= rsp_id;
      out_occupancy  <= sia_pkg::OCC_W'(count_next);
    end
  end

  for (genvar g = 0; g < MAX_SESSIONS; g++) begin : g_ent
    if (g < MAX_SESSIONS - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (cmd.update && login_ok && (count == CNT_W'(g))) begin
          ent_handle[g] <= req_handle;
          ent_offset[g] <= free_off;
        end else if (cmd.update && logout_hit && shift_ge[g]) begin
          ent_handle[g] <= ent_handle[g+1];
          ent_offset[g] <= ent_offset[g+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.update && login_ok && (count == CNT_W'(g))) begin
          ent_handle[g] <= req_handle;
          ent_offset[g] <= free_off;
        end
      end
    end
  end

endmodule

[tb/sv/sia_checker.sv]
// sia_checker: passive scoreboard for the session id allocator; tracks the session table,
// predicts each response and compares field by field. Depends on sia_pkg and sia_ifs.
module sia_checker #(
  parameter int unsigned MAX_SESSIONS = 32
) (
  input  logic        clk,
  input  logic        rst,
  sia_req_if          req,
  sia_rsp_if          rsp,
  sia_cfg_if          cfg,
  output int unsigned failures,
  output int unsigned pending,
  output int unsigned n_granted,
  output int unsigned n_full,
  output int unsigned n_removed,
  output int unsigned n_unknown,
  output int unsigned n_base_writes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sia_pkg::status_t                 status;
    logic [sia_pkg::ID_W-1:0]     session_id;
    logic [sia_pkg::OCC_W-1:0]    occupancy;
  } session_result_t;

  logic [sia_pkg::ID_W-1:0]     id_base;
  logic [sia_pkg::HANDLE_W-1:0] open_handle [MAX_SESSIONS];
  int unsigned                  open_offset [MAX_SESSIONS];
  int unsigned                  open_cnt;
  session_result_t              expected_q [$];
  int unsigned                  fail_cnt;
  int unsigned                  tally [4];
  int unsigned                  base_writes;

  // Table update for one accepted request; returns the response it must produce.
  function automatic session_result_t serve_request(logic kind,
                                                    logic [sia_pkg::HANDLE_W-1:0] h);
    session_result_t    r;
    logic [MAX_SESSIONS:0] taken;
    int                 free_off;
    int                 idx;
    r.session_id = '0;
    if (kind == sia_pkg::REQ_LOGIN) begin
      if (open_cnt >= MAX_SESSIONS) begin
        r.status = sia_pkg::ST_FULL;
      end else begin
        taken = '0;
        for (int i = 0; i < open_cnt; i++) taken[open_offset[i]] = 1'b1;
        free_off = MAX_SESSIONS;
        for (int i = MAX_SESSIONS - 1; i >= 0; i--) begin
          if (!taken[i]) free_off = i;
        end
        open_handle[open_cnt] = h;
        open_offset[open_cnt] = free_off;
        open_cnt++;
        r.status = sia_pkg::ST_GRANTED;
        r.session_id = id_base + sia_pkg::ID_W'(free_off);
      end
    end else begin
      idx = -1;
      for (int i = 0; i < open_cnt; i++) begin
        if (idx < 0 && open_handle[i] == h) idx = i;
      end
      if (idx < 0) begin
        r.status = sia_pkg::ST_NOT_FOUND;
      end else begin
        r.status = sia_pkg::ST_REMOVED;
        r.session_id = id_base + sia_pkg::ID_W'(open_offset[idx]);
        for (int j = idx; j + 1 < open_cnt; j++) begin
          open_handle[j] = open_handle[j + 1];
          open_offset[j] = open_offset[j + 1];
        end
        open_cnt--;
      end
    end
    r.occupancy = sia_pkg::OCC_W'(open_cnt);
    return r;
  endfunction

  task automatic report_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t ns: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    session_result_t want;
    if (rst) begin
      id_base = sia_pkg::ID_BASE_RESET;
      open_cnt = 0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        id_base = cfg.data;
        base_writes++;
      end
      if (req.valid && req.ready) expected_q.push_back(serve_request(req.req_type, req.handle));
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report_failure($sformatf("unexpected response: status %0d id %0d occupancy %0d",
                                   rsp.status, rsp.session_id, rsp.occupancy));
        end else begin
          want = expected_q.pop_front();
          tally[want.status]++;
          if (rsp.status !== want.status || rsp.session_id !== want.session_id ||
              rsp.occupancy !== want.occupancy) begin
            report_failure($sformatf(
              "mismatch: status exp %0d got %0d, id exp %0d got %0d, occupancy exp %0d got %0d",
              want.status, rsp.status, want.session_id, rsp.session_id,
              want.occupancy, rsp.occupancy));
          end
        end
      end
    end
    failures      <= fail_cnt;
    pending       <= expected_q.size();
    n_granted     <= tally[sia_pkg::ST_GRANTED];
    n_full        <= tally[sia_pkg::ST_FULL];
    n_removed     <= tally[sia_pkg::ST_REMOVED];
    n_unknown     <= tally[sia_pkg::ST_NOT_FOUND];
    n_base_writes <= base_writes;
  end

endmodule

[tb/sv/tb_top.sv]
// tb_top: stimulus and verdict for the session id allocator; random gaps and stalls,
// login/logout bursts and id_base changes. Depends on sia_pkg, sia_ifs, sia_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SESSIONS = 32;
  localparam int unsigned QUIET_LIMIT = 400;
  localparam int unsigned BURSTS = 10;
  localparam int unsigned BURST_LEN = 40;

  logic clk;
  logic rst;

  sia_req_if req_ch ();
  sia_rsp_if rsp_ch ();
  sia_cfg_if cfg_ch ();

  int unsigned failures, pending;
  int unsigned n_granted, n_full, n_removed, n_unknown, n_base_writes;
  int unsigned quiet;
  int unsigned sent;

  logic [sia_pkg::HANDLE_W-1:0] handle_pool [8];
  logic [sia_pkg::HANDLE_W-1:0] stray_q [$];

  session_id_allocator #(.MAX_SESSIONS(MAX_SESSIONS)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  sia_checker #(.MAX_SESSIONS(MAX_SESSIONS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .cfg           (cfg_ch),
    .failures      (failures),
    .pending       (pending),
    .n_granted     (n_granted),
    .n_full        (n_full),
    .n_removed     (n_removed),
    .n_unknown     (n_unknown),
    .n_base_writes (n_base_writes)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // valid stays high across back-to-back transfers; it only drops at a gap or in drain
  task automatic send_request(input logic kind, input logic [sia_pkg::HANDLE_W-1:0] h,
                              input bit eager);
    int unsigned gap;
    gap = eager ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.handle <= h;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [sia_pkg::ID_W-1:0] value);
    drain();
    cfg_ch.data <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [sia_pkg::HANDLE_W-1:0] login_handle();
    logic [sia_pkg::HANDLE_W-1:0] h;
    if ($urandom_range(0, 7) == 0) begin
      h = sia_pkg::HANDLE_W'($urandom);
      stray_q.push_back(h);
    end else begin
      h = handle_pool[$urandom_range(0, 7)];
    end
    return h;
  endfunction

  function automatic logic [sia_pkg::HANDLE_W-1:0] logout_handle();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return sia_pkg::HANDLE_W'($urandom);
    if (pick == 1 && stray_q.size() > 0) return stray_q.pop_front();
    return handle_pool[$urandom_range(0, 7)];
  endfunction

  // response side: per-transfer stall, with occasional stretches of none
  initial begin
    int unsigned calm;
    int unsigned stall;
    calm = 0;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (calm == 0 && $urandom_range(0, 7) == 0) calm = $urandom_range(20, 40);
      stall = (calm > 0) ? 0 : $urandom_range(0, 15);
      if (calm > 0) calm--;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned login_pct [BURSTS];
    logic [sia_pkg::ID_W-1:0] bases [BURSTS / 2];
    bit eager;
    logic kind;
    login_pct = '{95, 95, 50, 15, 50, 95, 30, 70, 10, 90};
    bases = '{16'd65000, 16'd0, 16'h7FFF, 16'hAAAA, 16'h5555};
    bases[2] = sia_pkg::ID_W'($urandom_range(0, 65000));
    sent = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= sia_pkg::REQ_LOGIN;
    req_ch.handle <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    handle_pool[0] = 16'h0000;
    handle_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) handle_pool[i] = sia_pkg::HANDLE_W'($urandom);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty logout, duplicates, gap close, reuse of freed id, base move
    send_request(sia_pkg::REQ_LOGOUT, 16'h0000, 0);
    send_request(sia_pkg::REQ_LOGIN,  16'h0000, 0);
    send_request(sia_pkg::REQ_LOGIN,  16'hFFFF, 0);
    send_request(sia_pkg::REQ_LOGIN,  16'h0000, 0);
    send_request(sia_pkg::REQ_LOGOUT, 16'h0000, 0);
    send_request(sia_pkg::REQ_LOGIN,  16'h8001, 1);
    send_request(sia_pkg::REQ_LOGOUT, 16'hFFFF, 1);
    send_request(sia_pkg::REQ_LOGOUT, 16'h1234, 0);
    send_request(sia_pkg::REQ_LOGIN,  16'h7FFE, 0);
    write_base(16'd65000);
    send_request(sia_pkg::REQ_LOGOUT, 16'h0000, 0);
    send_request(sia_pkg::REQ_LOGOUT, 16'h8001, 1);
    send_request(sia_pkg::REQ_LOGOUT, 16'h7FFE, 0);

    // bursts vary between login-heavy and logout-heavy; base changes with sessions still open
    for (int b = 0; b < BURSTS; b++) begin
      if (b % 2 == 1) write_base(bases[b / 2]);
      eager = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < BURST_LEN; k++) begin
        kind = ($urandom_range(0, 99) < login_pct[b]) ? sia_pkg::REQ_LOGIN
                                                       : sia_pkg::REQ_LOGOUT;
        send_request(kind, (kind == sia_pkg::REQ_LOGIN) ? login_handle() : logout_handle(),
                     eager);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests: %0d granted, %0d table full, %0d removed, %0d unknown handle.",
             sent, n_granted, n_full, n_removed, n_unknown);
    $display("id_base written %0d times, ranging over 0 to 65000.", n_base_writes);
    if (failures == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
